>>> src/pcpa_pkg.sv
package pcpa_pkg;

    localparam int ADDR_W = 36;
    localparam int CPU_ID_W = 3;

    localparam int CPU_COUNT_DEF = 8;
    localparam int MAX_PAGES_DEF = 32768;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 36'h0_8000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST = 36'h0_8800_0000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [CPU_ID_W-1:0] cpu_id;
        logic [ADDR_W-1:0]   page_addr;
    } pcpa_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic              alloc_ok;
        logic              free_error;
    } pcpa_rsp_t;

    typedef struct packed {
        logic accept;
        logic commit;
    } pcpa_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } pcpa_state_t;

endpackage

>>> src/pcpa_ctrl.sv
module pcpa_ctrl
    import pcpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output pcpa_cmd_t cmd
);

    pcpa_state_t state_reg;
    pcpa_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.accept = req_valid;
            end
            ST_COMMIT:
            begin
                cmd.commit = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_COMMIT && req_stall))
        else $error("accepted beat did not move to commit");

    a_commit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && !rsp_valid_reg) |=> (state_reg == ST_IDLE && rsp_valid_reg))
        else $error("commit with empty output slot did not finish");

    a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && rsp_valid_reg && rsp_stall) |=> (state_reg == ST_COMMIT))
        else $error("commit overran a stalled result");

    a_idle_no_new_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !rsp_valid_reg) |=> !rsp_valid_reg)
        else $error("result appeared without an item");
`endif

endmodule

>>> src/pcpa_dp.sv
module pcpa_dp
    import pcpa_pkg::*;
#(
    parameter int CPU_COUNT = CPU_COUNT_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcpa_cmd_t            cmd,
    input  pcpa_req_t            req,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output pcpa_rsp_t            rsp
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PN_W = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int CPU_IW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] next;
    } link_t;

    function automatic logic [CPU_IW-1:0] cpu_wrap(input logic [CPU_ID_W-1:0] id);
        logic [4:0] v;
        v = {2'b00, id};
        for (int k = 0; k < 8; k++)
        begin
            if (v >= 5'(CPU_COUNT))
            begin
                v = v - 5'(CPU_COUNT);
            end
        end
        return v[CPU_IW-1:0];
    endfunction

    // region registers
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] end_reg;

    // list state
    logic [IDX_W-1:0]     head_reg [CPU_COUNT];
    logic [CPU_COUNT-1:0] nonempty_reg;
    link_t                next_mem [MAX_PAGES];
    link_t                link_reg;

    // captured item
    logic              op_reg;
    logic [CPU_IW-1:0] cpu_reg;
    logic [CPU_IW-1:0] sel_reg;
    logic              found_reg;
    logic              bad_reg;
    logic [PN_W-1:0]   idx_raw_reg;

    pcpa_rsp_t rsp_reg;

    logic [CPU_IW-1:0] cpu_now;
    logic [CPU_IW-1:0] sel_now;
    logic              found_now;
    logic              bad_now;
    logic              free_ok;
    logic [PN_W-1:0]   page_num;

    // rotating search for the first non-empty list from the requester on
    always_comb
    begin
        logic [CPU_IW:0] c_wide;
        cpu_now = cpu_wrap(req.cpu_id);
        found_now = 1'b0;
        sel_now = '0;
        for (int i = 0; i < CPU_COUNT; i++)
        begin
            c_wide = {1'b0, cpu_now} + (CPU_IW+1)'(i);
            if (c_wide >= (CPU_IW+1)'(CPU_COUNT))
            begin
                c_wide = c_wide - (CPU_IW+1)'(CPU_COUNT);
            end
            if (!found_now && nonempty_reg[c_wide[CPU_IW-1:0]])
            begin
                found_now = 1'b1;
                sel_now = c_wide[CPU_IW-1:0];
            end
        end
    end

    assign bad_now = (|req.page_addr[PAGE_SHIFT-1:0]) ||
                     (req.page_addr < start_reg) ||
                     (req.page_addr >= end_reg);

    assign free_ok = !bad_reg && ({1'b0, idx_raw_reg} < (PN_W+1)'(MAX_PAGES));

    assign page_num = start_reg[ADDR_W-1:PAGE_SHIFT] + PN_W'(head_reg[sel_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= REGION_START_RST;
            end_reg <= REGION_END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_REGION_START: start_reg <= cfg_data;
                REG_REGION_END:   end_reg <= cfg_data;
                default:          start_reg <= start_reg;
            endcase
        end
    end

    // capture at accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= req.opcode;
            cpu_reg <= cpu_now;
            sel_reg <= sel_now;
            found_reg <= found_now;
            bad_reg <= bad_now;
            idx_raw_reg <= req.page_addr[ADDR_W-1:PAGE_SHIFT] -
                           start_reg[ADDR_W-1:PAGE_SHIFT];
        end
    end

    // link memory: read at accept, written on a good free at commit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            link_reg <= next_mem[head_reg[sel_now]];
        end
        if (cmd.commit && op_reg == OP_FREE && free_ok)
        begin
            next_mem[idx_raw_reg[IDX_W-1:0]] <= '{valid: nonempty_reg[cpu_reg],
                                                   next: head_reg[cpu_reg]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CPU_COUNT; i++)
            begin
                head_reg[i] <= '0;
            end
            nonempty_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (op_reg == OP_FREE)
            begin
                if (free_ok)
                begin
                    head_reg[cpu_reg] <= idx_raw_reg[IDX_W-1:0];
                    nonempty_reg[cpu_reg] <= 1'b1;
                end
            end
            else if (found_reg)
            begin
                head_reg[sel_reg] <= link_reg.next;
                nonempty_reg[sel_reg] <= link_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (op_reg == OP_FREE)
            begin
                rsp_reg.alloc_addr <= '0;
                rsp_reg.alloc_ok <= 1'b0;
                rsp_reg.free_error <= !free_ok;
            end
            else if (found_reg)
            begin
                rsp_reg.alloc_addr <= {page_num, {PAGE_SHIFT{1'b0}}};
                rsp_reg.alloc_ok <= 1'b1;
                rsp_reg.free_error <= 1'b0;
            end
            else
            begin
                rsp_reg.alloc_addr <= '0;
                rsp_reg.alloc_ok <= 1'b0;
                rsp_reg.free_error <= 1'b0;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

>>> src/per_cpu_page_free_list_allocator.sv
// Per-CPU page allocator: one LIFO free list per CPU, linked through an
// on-chip next-page memory, with stealing from other CPUs' lists.
//
// Channels:
//   req  (req_valid / req_stall): opcode, cpu_id, page_addr. One beat per
//        allocate or free.
//   rsp  (rsp_valid / rsp_stall): alloc_addr, alloc_ok, free_error. Exactly
//        one beat per request, in request order.
//   cfg  (cfg_valid / cfg_ready): region_start (index 0), region_end
//        (index 1). Always ready; write only while no request is in flight.
// Timing: a request is taken in the idle cycle, the link memory read (for
//   allocate) or the address check (for free) completes on that edge, and the
//   list update plus the result register load happen on the next edge unless
//   a stalled result still holds the output register. rsp_valid rises with
//   that load, and no new request is taken until it is done.
// Stall: a finished result waits in the output register; a new request may
//   still be taken, and its commit waits until the slot is free.
// Reset: all lists empty, region registers at their defaults. The link
//   memory is not cleared; only pushed entries are ever used.
module per_cpu_page_free_list_allocator
    import pcpa_pkg::*;
#(
    parameter int CPU_COUNT = CPU_COUNT_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  pcpa_req_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output pcpa_rsp_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    pcpa_cmd_t cmd;

    // config port never backpressures
    assign cfg_ready = 1'b1;

    pcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    pcpa_dp #(
        .CPU_COUNT  (CPU_COUNT),
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

>>> test/page_alloc_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels, keeps its own copy of
// the per-CPU free lists and checks every result beat in order.
module page_alloc_checker
    import pcpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_stall,
    input  pcpa_req_t            req,
    input  logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  pcpa_rsp_t            rsp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output int unsigned          mismatches,
    output int unsigned          outstanding
);

    localparam int REPORT_MAX = 10;
    localparam int IDX_W = $clog2(MAX_PAGES_DEF);

    logic [ADDR_W-1:0] rgn_start;
    logic [ADDR_W-1:0] rgn_end;

    logic [IDX_W-1:0] link_next [MAX_PAGES_DEF];
    logic             link_ok   [MAX_PAGES_DEF];
    logic [IDX_W-1:0] list_top  [CPU_COUNT_DEF];
    logic             list_full [CPU_COUNT_DEF];

    pcpa_rsp_t awaited_rsp [$];

    // Free pushes onto the CPU's list; allocate pops own list first, then
    // steals from the next non-empty list in rotating order.
    function automatic pcpa_rsp_t model_page_op(input pcpa_req_t r);
        pcpa_rsp_t        res;
        longint unsigned  addr;
        longint unsigned  base;
        longint unsigned  pg;
        int unsigned      cpu;
        int unsigned      c;
        logic [IDX_W-1:0] idx;
        logic             hit;
        res  = '0;
        addr = r.page_addr;
        base = rgn_start / PAGE_BYTES_DEF;
        cpu  = r.cpu_id % CPU_COUNT_DEF;
        hit  = 1'b0;
        idx  = '0;
        if (r.opcode == OP_FREE) begin
            if (addr % PAGE_BYTES_DEF != 0 || addr < rgn_start || addr >= rgn_end) begin
                res.free_error = 1'b1;
            end
            else begin
                pg = addr / PAGE_BYTES_DEF - base;
                if (pg >= MAX_PAGES_DEF) begin
                    res.free_error = 1'b1;
                end
                else begin
                    link_next[pg]  = list_top[cpu];
                    link_ok[pg]    = list_full[cpu];
                    list_top[cpu]  = IDX_W'(pg);
                    list_full[cpu] = 1'b1;
                end
            end
        end
        else begin
            for (int i = 0; i < CPU_COUNT_DEF; i++) begin
                c = (cpu + i) % CPU_COUNT_DEF;
                if (!hit && list_full[c]) begin
                    hit          = 1'b1;
                    idx          = list_top[c];
                    list_full[c] = link_ok[idx];
                    list_top[c]  = link_next[idx];
                end
            end
            if (hit) begin
                res.alloc_addr = ADDR_W'((base + idx) * PAGE_BYTES_DEF);
                res.alloc_ok   = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pcpa_rsp_t want;
        if (!rst_n) begin
            rgn_start = REGION_START_RST;
            rgn_end   = REGION_END_RST;
            for (int c = 0; c < CPU_COUNT_DEF; c++) begin
                list_top[c]  = '0;
                list_full[c] = 1'b0;
            end
            awaited_rsp.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else begin
            // Result first: a beat leaving now belongs to an older request.
            if (rsp_valid && !rsp_stall) begin
                if (awaited_rsp.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t result beat with none pending: addr=%h ok=%b err=%b",
                                 $time, rsp.alloc_addr, rsp.alloc_ok, rsp.free_error);
                    mismatches++;
                end
                else begin
                    want = awaited_rsp.pop_front();
                    if (rsp.alloc_addr !== want.alloc_addr || rsp.alloc_ok !== want.alloc_ok
                        || rsp.free_error !== want.free_error) begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t result mismatch: exp addr=%h ok=%b err=%b, got addr=%h ok=%b err=%b",
                                     $time, want.alloc_addr, want.alloc_ok, want.free_error,
                                     rsp.alloc_addr, rsp.alloc_ok, rsp.free_error);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_REGION_START)
                    rgn_start = cfg_data;
                else if (cfg_index == REG_REGION_END)
                    rgn_end = cfg_data;
            end
            if (req_valid && !req_stall)
                awaited_rsp.push_back(model_page_op(req));
            outstanding = awaited_rsp.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcpa_pkg::*;

    // Receiver hold-off length for the pressure test, and the number of
    // cycles without any beat on any channel that counts as a hang.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    pcpa_req_t            req;
    logic                 rsp_valid;
    logic                 rsp_stall;
    pcpa_rsp_t            rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    int unsigned mismatches;
    int unsigned outstanding;

    // Idle percentages of sender and receiver; changed between phases.
    int src_idle;
    int dst_idle;
    logic hold_req;

    // Region currently programmed, so frees can aim inside it.
    logic [ADDR_W-1:0] cur_start;
    logic [ADDR_W-1:0] cur_end;

    per_cpu_page_free_list_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    page_alloc_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stall at the falling edge, plus one long
    // hold-off when asked for, counted here so the sender keeps running.
    initial
    begin
        int hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < dst_idle);
            end
        end
    end

    // Hang detection: any beat on any channel restarts the count.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // Aligned page inside the current region; mostly the low 64 pages so
    // lists collide and double frees happen, sometimes anywhere (which in a
    // big region lands past the last trackable page).
    function automatic logic [ADDR_W-1:0] pick_page();
        longint unsigned s;
        longint unsigned e;
        longint unsigned first_pg;
        longint unsigned end_pg;
        longint unsigned k;
        s = cur_start;
        e = cur_end;
        first_pg = (s + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
        end_pg   = (e + PAGE_BYTES_DEF - 1) / PAGE_BYTES_DEF;
        if (end_pg <= first_pg)
            return rand_addr();
        if ($urandom_range(99) < 85)
            k = $urandom_range(63);
        else
            k = $urandom();
        k = k % (end_pg - first_pg);
        return ADDR_W'((first_pg + k) * PAGE_BYTES_DEF);
    endfunction

    // One request beat. Entered and left at a falling edge; valid is left
    // high so back-to-back beats never drop it for a cycle.
    task automatic push_req(input logic op, input logic [CPU_ID_W-1:0] cpu,
                            input logic [ADDR_W-1:0] addr);
        pcpa_req_t beat;
        beat.opcode    = op;
        beat.cpu_id    = cpu;
        beat.page_addr = addr;
        while ($urandom_range(99) < src_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop requests and wait until every result has come back, then wait out
    // the given tail so the pipe can settle.
    task automatic quiesce(input int tail);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    // Reprogram both region registers while the block is idle.
    task automatic set_region(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] e);
        quiesce(8);
        for (int i = 0; i < 2; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i == 0) ? REG_REGION_START : REG_REGION_END;
            cfg_data  <= (i == 0) ? s : e;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cur_start = s;
        cur_end   = e;
    endtask

    // Mostly well-formed frees and allocates with a free/alloc mix that
    // drifts, so lists fill up, drain dry and get stolen from; a slice of
    // junk opcodes/addresses and misaligned in-region frees on top.
    task automatic run_random(input int count);
        int free_pct;
        int roll;
        free_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                free_pct = $urandom_range(10, 85);
            roll = $urandom_range(99);
            if (roll < 6)
                push_req(1'($urandom_range(1)), CPU_ID_W'($urandom_range(7)), rand_addr());
            else if (roll < 10)
                push_req(OP_FREE, CPU_ID_W'($urandom_range(7)),
                         pick_page() | ADDR_W'($urandom_range(1, PAGE_BYTES_DEF - 1)));
            else if ($urandom_range(99) < free_pct)
                push_req(OP_FREE, CPU_ID_W'($urandom_range(7)), pick_page());
            else
                push_req(OP_ALLOC, CPU_ID_W'($urandom_range(7)), rand_addr());
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_REGION_START;
        cfg_data  = '0;
        hold_req  = 1'b0;
        cur_start = REGION_START_RST;
        cur_end   = REGION_END_RST;
        src_idle  = 29;
        dst_idle  = 69;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset region. Empty lists fail, bad frees are flagged and change
        // nothing, lowest/highest pages are accepted, LIFO order, stealing
        // in rotating order, and a double-freed page handed out twice.
        // Allocate beats carry junk addresses, which must be ignored.
        push_req(OP_ALLOC, 3'd0, '1);
        push_req(OP_ALLOC, 3'd7, '0);
        push_req(OP_FREE,  3'd0, '0);
        push_req(OP_FREE,  3'd0, REGION_START_RST + 36'h800);
        push_req(OP_FREE,  3'd2, REGION_END_RST);
        push_req(OP_FREE,  3'd5, '1);
        push_req(OP_FREE,  3'd6, 36'hF_FFFF_F000);
        push_req(OP_FREE,  3'd0, REGION_START_RST);
        push_req(OP_FREE,  3'd7, REGION_END_RST - PAGE_BYTES_DEF);
        push_req(OP_FREE,  3'd3, REGION_START_RST + 36'h5000);
        push_req(OP_FREE,  3'd3, REGION_START_RST + 36'h9000);
        push_req(OP_ALLOC, 3'd3, 36'h5_A5A5_A5A5);
        push_req(OP_ALLOC, 3'd3, '0);
        push_req(OP_ALLOC, 3'd3, '0);       // steals from CPU 7 before CPU 0
        push_req(OP_ALLOC, 3'd3, '0);       // then CPU 0
        push_req(OP_ALLOC, 3'd3, '0);       // everything empty again
        push_req(OP_FREE,  3'd1, REGION_START_RST + 36'h2000);
        push_req(OP_FREE,  3'd1, REGION_START_RST + 36'h2000);
        push_req(OP_ALLOC, 3'd1, '0);
        push_req(OP_ALLOC, 3'd1, '0);
        push_req(OP_ALLOC, 3'd4, '1);
        run_random(500);

        // Whole address space: the page-index limit now bites before the
        // region end does.
        set_region('0, '1);
        push_req(OP_FREE,  3'd4, 36'h0_0800_0000);
        push_req(OP_FREE,  3'd4, 36'h0_07FF_F000);
        push_req(OP_ALLOC, 3'd2, '0);
        run_random(400);

        // Roles swapped: sluggish sender, busy receiver. Region at the very
        // top, so returned addresses wrap past 36 bits.
        src_idle = 69;
        dst_idle = 29;
        set_region(36'hF_FFFF_0000, '1);
        run_random(300);

        // Inverted region: every free is rejected, allocates drain the lists.
        set_region('1, '0);
        run_random(150);

        // No idling at all, unaligned region start, and one long receiver
        // hold-off so the block backs up into the request side.
        src_idle = 0;
        dst_idle = 0;
        set_region(36'h0_0000_0800, 36'h0_0400_0000);
        hold_req = 1'b1;
        run_random(580);

        quiesce(20);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> per_cpu_page_free_list_allocator.f
src/pcpa_pkg.sv
src/pcpa_ctrl.sv
src/pcpa_dp.sv
src/per_cpu_page_free_list_allocator.sv
test/page_alloc_checker.sv
test/tb_top.sv
